// File: hw/rtl/segtree_pkg.sv
package segtree_pkg;

  localparam int LEAF_COUNT  = 1024;
  localparam int LEAF_W      = $clog2(LEAF_COUNT);
  localparam int CNT_W       = $clog2(LEAF_COUNT + 1);
  localparam int NODE_SLOTS  = 4 * LEAF_COUNT;
  localparam int NODE_W      = $clog2(NODE_SLOTS);
  localparam int STACK_DEPTH = LEAF_W;
  localparam int STK_IDX_W   = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 64;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = CNT_W;

  localparam logic [MODE_W-1:0] MODE_SUM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COMBINE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USED_LEAVES  = 1'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    DC_NONE,
    DC_CLEAR,
    DC_LOAD,
    DC_W_DESC,
    DC_W_LEAF,
    DC_W_UP,
    DC_Q_STEP,
    DC_OUT
  } dp_cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_W_DESC,
    ST_W_UP,
    ST_Q_WALK,
    ST_Q_DRAIN,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic clear_last;
    logic in_err;
    logic in_query;
    logic leaf_hit;
    logic at_root;
    logic parent_root;
    logic q_last;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [LEAF_W-1:0] lo;
    logic [LEAF_W-1:0] hi;
  } stk_entry_t;

  function automatic logic [DATA_W-1:0] seg_combine(logic [MODE_W-1:0] mode,
                                                    logic [DATA_W-1:0] a,
                                                    logic [DATA_W-1:0] b);
    logic a_less;
    logic [DATA_W-1:0] res;
    a_less = $signed(a) < $signed(b);
    unique case (mode)
      MODE_MAX: res = a_less ? b : a;
      MODE_MIN: res = a_less ? a : b;
      default:  res = a + b;
    endcase
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] seg_identity(logic [MODE_W-1:0] mode);
    logic [DATA_W-1:0] res;
    unique case (mode)
      MODE_MAX: res = {1'b1, {(DATA_W-1){1'b0}}};
      MODE_MIN: res = {1'b0, {(DATA_W-1){1'b1}}};
      default:  res = '0;
    endcase
    return res;
  endfunction

endpackage

// File: hw/rtl/segtree_ctrl.sv
module segtree_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  segtree_pkg::dp_status_t dp_stat_i,
  output segtree_pkg::dp_cmd_e   dp_cmd_o
);
  import segtree_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    dp_cmd_o = DC_NONE;
    unique case (state_q)
      ST_CLEAR: begin
        dp_cmd_o = DC_CLEAR;
        if (dp_stat_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          dp_cmd_o = DC_LOAD;
          priority if (dp_stat_i.in_err) state_d = ST_FINISH;
          else if (dp_stat_i.in_query) state_d = ST_Q_WALK;
          else state_d = ST_W_DESC;
        end
      end
      ST_W_DESC: begin
        if (dp_stat_i.leaf_hit) begin
          dp_cmd_o = DC_W_LEAF;
          state_d  = dp_stat_i.at_root ? ST_FINISH : ST_W_UP;
        end else begin
          dp_cmd_o = DC_W_DESC;
        end
      end
      ST_W_UP: begin
        dp_cmd_o = DC_W_UP;
        if (dp_stat_i.parent_root) state_d = ST_FINISH;
      end
      ST_Q_WALK: begin
        dp_cmd_o = DC_Q_STEP;
        if (dp_stat_i.q_last) state_d = ST_Q_DRAIN;
      end
      ST_Q_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (dp_stat_i.out_free) begin
          dp_cmd_o = DC_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// File: hw/rtl/segtree_dp.sv
module segtree_dp (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  segtree_pkg::dp_cmd_e                       dp_cmd_i,
  output segtree_pkg::dp_status_t                    dp_stat_o,
  input  logic                                       cfg_we_i,
  input  logic [segtree_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [segtree_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                       command_i,
  input  logic [segtree_pkg::LEAF_W-1:0]             leaf_index_i,
  input  logic signed [segtree_pkg::DATA_W-1:0]      leaf_value_i,
  input  logic [segtree_pkg::LEAF_W-1:0]             range_low_i,
  input  logic [segtree_pkg::LEAF_W-1:0]             range_high_i,
  input  logic                                       out_stall_i,
  output logic                                       out_valid_o,
  output logic signed [segtree_pkg::DATA_W-1:0]      answer_o,
  output logic                                       status_o
);
  import segtree_pkg::*;

  logic [MODE_W-1:0] mode_q;
  logic [CNT_W-1:0]  used_q;
  logic [CNT_W-1:0]  n_eff;
  logic [LEAF_W-1:0] last_leaf;
  logic              in_err;

  logic              query_q, err_q;
  logic [LEAF_W-1:0] idx_q, ql_q, qr_q, lo_q, hi_q;
  logic [DATA_W-1:0] val_q, cur_q, acc_q, rdata_q;
  logic [NODE_W-1:0] node_q;
  logic              acc_en_q;
  logic [NODE_W-1:0] clr_q;
  logic [SP_W-1:0]   sp_q, sp_dec;
  stk_entry_t        stack_q [STACK_DEPTH];
  stk_entry_t        stk_top;

  logic              out_valid_q, status_q;
  logic [DATA_W-1:0] answer_q;

  logic [DATA_W-1:0] mem [NODE_SLOTS];
  logic              mem_we, mem_re;
  logic [NODE_W-1:0] mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata;

  logic [CNT_W-1:0]  lohi_sum;
  logic [LEAF_W-1:0] mid, mid_p1;
  logic [NODE_W-1:0] lchild, rchild, pm1, parent, sib_node, sib_par;
  logic [DATA_W-1:0] combined_up;
  logic              covered, go_left, go_right, stack_empty, push;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SUM;
      used_q <= CNT_W'(LEAF_COUNT);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_COMBINE_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
        REG_USED_LEAVES:  used_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (used_q == '0) n_eff = CNT_W'(1);
    else if (used_q > CNT_W'(LEAF_COUNT)) n_eff = CNT_W'(LEAF_COUNT);
    else n_eff = used_q;
  end

  assign last_leaf = LEAF_W'(n_eff - CNT_W'(1));

  always_comb begin
    if (command_i == OP_QUERY) begin
      in_err = (range_low_i > range_high_i) || ({1'b0, range_high_i} >= n_eff);
    end else begin
      in_err = ({1'b0, leaf_index_i} >= n_eff);
    end
  end

  // tree navigation
  assign lohi_sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid         = lohi_sum[LEAF_W:1];
  assign mid_p1      = mid + LEAF_W'(1);
  assign lchild      = {node_q[NODE_W-2:0], 1'b0} + NODE_W'(1);
  assign rchild      = {node_q[NODE_W-2:0], 1'b0} + NODE_W'(2);
  assign pm1         = node_q - NODE_W'(1);
  assign parent      = {1'b0, pm1[NODE_W-1:1]};
  assign sib_node    = node_q[0] ? node_q + NODE_W'(1) : node_q - NODE_W'(1);
  assign sib_par     = parent[0] ? parent + NODE_W'(1) : parent - NODE_W'(1);
  assign combined_up = seg_combine(mode_q, cur_q, rdata_q);

  assign covered     = (lo_q == hi_q) || ((ql_q <= lo_q) && (hi_q <= qr_q));
  assign go_left     = (ql_q <= mid);
  assign go_right    = (qr_q > mid);
  assign stack_empty = (sp_q == '0);
  assign sp_dec      = sp_q - SP_W'(1);
  assign stk_top     = stack_q[sp_dec[STK_IDX_W-1:0]];
  assign push        = (dp_cmd_i == DC_Q_STEP) && !covered && go_left && go_right;

  assign dp_stat_o.clear_last  = (clr_q == NODE_W'(NODE_SLOTS - 1));
  assign dp_stat_o.in_err      = in_err;
  assign dp_stat_o.in_query    = (command_i == OP_QUERY);
  assign dp_stat_o.leaf_hit    = (lo_q == hi_q);
  assign dp_stat_o.at_root     = (node_q == '0);
  assign dp_stat_o.parent_root = (parent == '0);
  assign dp_stat_o.q_last      = covered && stack_empty;
  assign dp_stat_o.out_free    = !out_valid_q || !out_stall_i;

  // node memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node_q;
    mem_wdata = val_q;
    mem_re    = 1'b0;
    mem_raddr = node_q;
    unique case (dp_cmd_i)
      DC_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      DC_W_LEAF: begin
        mem_we    = 1'b1;
        mem_re    = (node_q != '0);
        mem_raddr = sib_node;
      end
      DC_W_UP: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = combined_up;
        mem_re    = (parent != '0);
        mem_raddr = sib_par;
      end
      DC_Q_STEP: begin
        mem_re = covered;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      sp_q        <= '0;
      acc_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_en_q <= (dp_cmd_i == DC_Q_STEP) && covered;
      if (dp_cmd_i == DC_CLEAR) clr_q <= clr_q + NODE_W'(1);
      if (dp_cmd_i == DC_LOAD) sp_q <= '0;
      else if (push) sp_q <= sp_q + SP_W'(1);
      else if ((dp_cmd_i == DC_Q_STEP) && covered && !stack_empty) sp_q <= sp_dec;
      if (dp_cmd_i == DC_OUT) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // item and walk registers
  always_ff @(posedge clk_i) begin
    if (push) stack_q[sp_q[STK_IDX_W-1:0]] <= '{node: rchild, lo: mid_p1, hi: hi_q};

    if (dp_cmd_i == DC_LOAD) acc_q <= seg_identity(mode_q);
    else if (acc_en_q) acc_q <= seg_combine(mode_q, acc_q, rdata_q);

    unique case (dp_cmd_i)
      DC_LOAD: begin
        query_q <= (command_i == OP_QUERY);
        err_q   <= in_err;
        idx_q   <= leaf_index_i;
        val_q   <= leaf_value_i;
        ql_q    <= range_low_i;
        qr_q    <= range_high_i;
        node_q  <= '0;
        lo_q    <= '0;
        hi_q    <= last_leaf;
      end
      DC_W_DESC: begin
        if (idx_q <= mid) begin
          node_q <= lchild;
          hi_q   <= mid;
        end else begin
          node_q <= rchild;
          lo_q   <= mid_p1;
        end
      end
      DC_W_LEAF: begin
        cur_q <= val_q;
      end
      DC_W_UP: begin
        node_q <= parent;
        cur_q  <= combined_up;
      end
      DC_Q_STEP: begin
        if (covered) begin
          if (!stack_empty) begin
            node_q <= stk_top.node;
            lo_q   <= stk_top.lo;
            hi_q   <= stk_top.hi;
          end
        end else if (go_left) begin
          node_q <= lchild;
          hi_q   <= mid;
        end else begin
          node_q <= rchild;
          lo_q   <= mid_p1;
        end
      end
      DC_OUT: begin
        answer_q <= (err_q || !query_q) ? '0 : acc_q;
        status_q <= err_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign answer_o    = answer_q;
  assign status_o    = status_q;

endmodule

// File: hw/rtl/segment_tree_point_update_range_query_top.sv
// Channel   Handshake               Payload
// input     in_valid_i / in_stall_o  command_i, leaf_index_i, leaf_value_i, range_low_i/high_i
// output    out_valid_o / out_stall_i answer_o, status_o
// config    cfg_we_i                 cfg_index_i, cfg_data_i
//
// A write walks the tree (d = tree depth, 10 at 1024 leaves): one node step per
// level down, then one sibling read and parent write per level up on the node memory.
// A query walks the tree one node at a time, visiting at most about 4*d nodes.
// After reset a clearing pass zeroes the 4096-word node memory.
// The result word sits in an output register; the next word is taken and worked on
// while it waits, and only the hand-off of that next result holds for out_stall_i.
module segment_tree_point_update_range_query_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  command_i,
  input  logic [segtree_pkg::LEAF_W-1:0]        leaf_index_i,
  input  logic signed [segtree_pkg::DATA_W-1:0] leaf_value_i,
  input  logic [segtree_pkg::LEAF_W-1:0]        range_low_i,
  input  logic [segtree_pkg::LEAF_W-1:0]        range_high_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [segtree_pkg::DATA_W-1:0] answer_o,
  output logic                                  status_o,
  input  logic                                  cfg_we_i,
  input  logic [segtree_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [segtree_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import segtree_pkg::*;

  dp_cmd_e    dp_cmd;
  dp_status_t dp_stat;

  segtree_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .dp_stat_i  (dp_stat),
    .dp_cmd_o   (dp_cmd)
  );

  segtree_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dp_cmd_i     (dp_cmd),
    .dp_stat_o    (dp_stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .command_i    (command_i),
    .leaf_index_i (leaf_index_i),
    .leaf_value_i (leaf_value_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .answer_o     (answer_o),
    .status_o     (status_o)
  );

endmodule
